FILE: src/relation_property_checker_unit_defines.svh
// Assertion helpers shared by the RTL.
`ifndef RELATION_PROPERTY_CHECKER_UNIT_DEFINES_SVH
`define RELATION_PROPERTY_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define RPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/rpc_pkg.sv
package rpc_pkg;

    localparam int MATRIX_W   = 64;
    localparam int ROW_W      = 8;
    localparam int FLAGS_W    = 17;
    localparam int ELEM_COUNT_W = 4;

    localparam logic [ELEM_COUNT_W-1:0] ELEM_COUNT_RESET = 4'd8;

    // flag positions in the result word
    localparam int FLAG_ANTISYM = 0;
    localparam int FLAG_ANTITR  = 1;
    localparam int FLAG_ASYM    = 2;
    localparam int FLAG_COREF   = 3;
    localparam int FLAG_DENS    = 4;
    localparam int FLAG_IRR     = 5;
    localparam int FLAG_LEUC    = 6;
    localparam int FLAG_LQR     = 7;
    localparam int FLAG_QR      = 8;
    localparam int FLAG_REFL    = 9;
    localparam int FLAG_REUC    = 10;
    localparam int FLAG_RQR     = 11;
    localparam int FLAG_SDENS   = 12;
    localparam int FLAG_SYM     = 13;
    localparam int FLAG_TOTAL   = 14;
    localparam int FLAG_TRANS   = 15;
    localparam int FLAG_TRICH   = 16;

    // per-row violation bits, set when the row breaks the property
    typedef struct packed {
        logic antisym;
        logic antitr;
        logic coref;
        logic dens;
        logic irr;
        logic leuc;
        logic lqr;
        logic refl;
        logic reuc;
        logic rqr;
        logic sdens;
        logic sym;
        logic trans;
        logic trich;
    } t_row_chk;

endpackage

FILE: src/relation_property_checker_unit.sv
// Relation property checker: takes one 8x8 relation matrix per request and returns
// 17 property flags. Fully pipelined over three register stages (masking, per-row
// checks, reduction to flags): one request per cycle sustained while the output is ready;
// a result passes through the masked-matrix, row-check and flag registers, with
// backpressure from the output stalling the stages in turn. The element count is
// sampled as a request enters; rows and columns at or above it are masked off, and
// an empty set gives all flags set.
`include "relation_property_checker_unit_defines.svh"

module relation_property_checker_unit #(
    parameter int MAX_ELEMENTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rpc_pkg::ELEM_COUNT_W-1:0] i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [rpc_pkg::MATRIX_W-1:0]     i_relation_matrix,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [rpc_pkg::FLAGS_W-1:0]      o_property_flags
);

    localparam int N = MAX_ELEMENTS;

    logic [rpc_pkg::ELEM_COUNT_W-1:0] r_elem_count;

    logic en1, en2, en3;

    logic                r_v1, r_v2, r_v3;
    logic [N-1:0]        r_m [N];
    logic [N-1:0]        n_m [N];
    logic [N-1:0]        r_elem1;
    logic [N-1:0]        n_elem;
    rpc_pkg::t_row_chk   r_chk [N];
    rpc_pkg::t_row_chk   n_chk [N];
    logic [rpc_pkg::FLAGS_W-1:0] r_flags;
    logic [rpc_pkg::FLAGS_W-1:0] n_flags;
    logic [N-1:0]        mt [N];

    assign en3        = !r_v3 || i_out_ready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= rpc_pkg::ELEM_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_elem_count <= i_cfg_wr_data;
        end
    end

    // stage 1: element mask and masked matrix
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_elem[i] = (rpc_pkg::ELEM_COUNT_W'(i) < r_elem_count);
        end
        for (int i = 0; i < N; i++) begin
            n_m[i] = n_elem[i] ? (i_relation_matrix[i*rpc_pkg::ROW_W +: N] & n_elem) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_m     <= n_m;
            r_elem1 <= n_elem;
        end
    end

    // stage 2: per-row checks, each row against all columns
    always_comb begin
        for (int r = 0; r < N; r++) begin
            for (int c = 0; c < N; c++) begin
                mt[c][r] = r_m[r][c];
            end
        end
    end

    always_comb begin
        logic [N-1:0] oh_i;
        logic [N-1:0] oh_j;
        logic [N-1:0] row;
        for (int i = 0; i < N; i++) begin
            oh_i = N'(1) << i;
            row  = r_m[i];
            n_chk[i].irr     = row[i];
            n_chk[i].refl    = r_elem1[i] && !row[i];
            n_chk[i].coref   = |(row & ~oh_i);
            n_chk[i].antisym = |(row & mt[i] & ~oh_i);
            n_chk[i].sym     = |(row ^ mt[i]);
            n_chk[i].trich   = r_elem1[i] && (|(~(row | mt[i]) & r_elem1 & ~oh_i));
            n_chk[i].antitr  = 1'b0;
            n_chk[i].trans   = 1'b0;
            n_chk[i].reuc    = 1'b0;
            n_chk[i].leuc    = 1'b0;
            n_chk[i].dens    = 1'b0;
            n_chk[i].sdens   = 1'b0;
            n_chk[i].lqr     = 1'b0;
            n_chk[i].rqr     = 1'b0;
            for (int j = 0; j < N; j++) begin
                oh_j = N'(1) << j;
                if (row[j]) begin
                    if (|(row & r_m[j]))  n_chk[i].antitr = 1'b1;
                    if (|(r_m[j] & ~row)) n_chk[i].trans  = 1'b1;
                    if (|(row & ~r_m[j])) n_chk[i].reuc   = 1'b1;
                    // column j inside row i, for each pair with i R j
                    if (|(mt[j] & ~row))  n_chk[i].leuc   = 1'b1;
                    if (!(|(row & mt[j]))) n_chk[i].dens  = 1'b1;
                    if (i != j) begin
                        if (!(|(row & mt[j] & ~oh_i & ~oh_j))) n_chk[i].sdens = 1'b1;
                        if (!row[i])    n_chk[i].lqr = 1'b1;
                        if (!r_m[j][j]) n_chk[i].rqr = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_chk <= n_chk;
        end
    end

    // stage 3: fold rows into flags
    always_comb begin
        rpc_pkg::t_row_chk acc;
        acc = '0;
        for (int i = 0; i < N; i++) begin
            acc = rpc_pkg::t_row_chk'(acc | r_chk[i]);
        end
        n_flags = '0;
        n_flags[rpc_pkg::FLAG_ANTISYM] = !acc.antisym;
        n_flags[rpc_pkg::FLAG_ANTITR]  = !acc.antitr;
        n_flags[rpc_pkg::FLAG_ASYM]    = !acc.antisym && !acc.irr;
        n_flags[rpc_pkg::FLAG_COREF]   = !acc.coref;
        n_flags[rpc_pkg::FLAG_DENS]    = !acc.dens;
        n_flags[rpc_pkg::FLAG_IRR]     = !acc.irr;
        n_flags[rpc_pkg::FLAG_LEUC]    = !acc.leuc;
        n_flags[rpc_pkg::FLAG_LQR]     = !acc.lqr;
        n_flags[rpc_pkg::FLAG_QR]      = !acc.lqr && !acc.rqr;
        n_flags[rpc_pkg::FLAG_REFL]    = !acc.refl;
        n_flags[rpc_pkg::FLAG_REUC]    = !acc.reuc;
        n_flags[rpc_pkg::FLAG_RQR]     = !acc.rqr;
        n_flags[rpc_pkg::FLAG_SDENS]   = !acc.sdens;
        n_flags[rpc_pkg::FLAG_SYM]     = !acc.sym;
        n_flags[rpc_pkg::FLAG_TOTAL]   = !acc.refl && !acc.trich;
        n_flags[rpc_pkg::FLAG_TRANS]   = !acc.trans;
        n_flags[rpc_pkg::FLAG_TRICH]   = !acc.trich;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_flags <= n_flags;
        end
    end

    assign o_out_valid      = r_v3;
    assign o_property_flags = r_flags;

    // coreflexive relations are symmetric, antisymmetric and transitive
    `RPC_ASSERT_IMP(a_coref_implies, r_v3 && r_flags[rpc_pkg::FLAG_COREF], r_flags[rpc_pkg::FLAG_SYM] && r_flags[rpc_pkg::FLAG_ANTISYM] && r_flags[rpc_pkg::FLAG_TRANS])
    // reflexive relations are dense
    `RPC_ASSERT_IMP(a_refl_dense, r_v3 && r_flags[rpc_pkg::FLAG_REFL], r_flags[rpc_pkg::FLAG_DENS])
    // a stalled middle stage keeps its request
    `RPC_ASSERT_NXT(a_s2_hold, r_v2 && !en3, r_v2 && r_v3)
    // a stalled first stage keeps its request
    `RPC_ASSERT_NXT(a_s1_hold, r_v1 && !en2, r_v1 && r_v2)

endmodule

FILE: verif/relation_flags_checker.sv
module relation_flags_checker #(
    parameter int MAX_ELEMENTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rpc_pkg::ELEM_COUNT_W-1:0] i_cfg_wr_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [rpc_pkg::MATRIX_W-1:0]     i_relation_matrix,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [rpc_pkg::FLAGS_W-1:0]      i_property_flags,
    output int                               o_pending,
    output int                               o_fail_count
);

    logic [rpc_pkg::ELEM_COUNT_W-1:0] elem_count_q;
    logic [rpc_pkg::FLAGS_W-1:0]    expected_flags [$];
    logic [rpc_pkg::FLAGS_W-1:0]    want;
    int                             errors = 0;

    function automatic logic [rpc_pkg::FLAGS_W-1:0] relation_flags(
        input logic [rpc_pkg::MATRIX_W-1:0]     rel,
        input logic [rpc_pkg::ELEM_COUNT_W-1:0] size
    );
        int n, i, j, k;
        logic [7:0] m [8];
        logic [8:0] mask;
        logic antisym, antitr, coref, dens, irr, leuc, lqr, refl;
        logic reuc, rqr, sdens, sym, trans, trich, found, sfound, rij, rji;
        logic [rpc_pkg::FLAGS_W-1:0] f;

        n = (int'(size) > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(size);
        if (n > 8)
            n = 8;
        mask = (9'd1 << n) - 9'd1;
        for (i = 0; i < 8; i++)
            m[i] = (i < n) ? (rel[8*i +: 8] & mask[7:0]) : 8'd0;

        antisym = 1'b1; antitr = 1'b1; coref = 1'b1; dens = 1'b1; irr = 1'b1;
        leuc = 1'b1; lqr = 1'b1; refl = 1'b1; reuc = 1'b1; rqr = 1'b1;
        sdens = 1'b1; sym = 1'b1; trans = 1'b1; trich = 1'b1;

        for (i = 0; i < n; i++) begin
            if (m[i][i])
                irr = 1'b0;
            else
                refl = 1'b0;
            if (|(m[i] & ~(8'd1 << i)))
                coref = 1'b0;
            for (j = 0; j < n; j++) begin
                rij = m[i][j];
                rji = m[j][i];
                if (j > i) begin
                    if (rij && rji)
                        antisym = 1'b0;
                    if (rij != rji)
                        sym = 1'b0;
                    if (!(rij || rji))
                        trich = 1'b0;
                end
                if (rij) begin
                    if (|(m[i] & m[j]))
                        antitr = 1'b0;
                    if (|(m[j] & ~m[i]))
                        trans = 1'b0;
                    found = 1'b0;
                    sfound = 1'b0;
                    for (k = 0; k < n; k++) begin
                        if (m[i][k] && m[k][j]) begin
                            found = 1'b1;
                            if (k != i && k != j)
                                sfound = 1'b1;
                        end
                    end
                    if (!found)
                        dens = 1'b0;
                    if (i != j && !sfound)
                        sdens = 1'b0;
                    if (i != j) begin
                        if (!m[i][i])
                            lqr = 1'b0;
                        if (!m[j][j])
                            rqr = 1'b0;
                    end
                end
                for (k = 0; k < n; k++) begin
                    if (rij && m[i][k] && !m[j][k])
                        reuc = 1'b0;
                    if (m[j][i] && m[k][i] && !m[j][k])
                        leuc = 1'b0;
                end
            end
        end

        f = '0;
        f[rpc_pkg::FLAG_ANTISYM] = antisym;
        f[rpc_pkg::FLAG_ANTITR]  = antitr;
        f[rpc_pkg::FLAG_ASYM]    = antisym && irr;
        f[rpc_pkg::FLAG_COREF]   = coref;
        f[rpc_pkg::FLAG_DENS]    = dens;
        f[rpc_pkg::FLAG_IRR]     = irr;
        f[rpc_pkg::FLAG_LEUC]    = leuc;
        f[rpc_pkg::FLAG_LQR]     = lqr;
        f[rpc_pkg::FLAG_QR]      = lqr && rqr;
        f[rpc_pkg::FLAG_REFL]    = refl;
        f[rpc_pkg::FLAG_REUC]    = reuc;
        f[rpc_pkg::FLAG_RQR]     = rqr;
        f[rpc_pkg::FLAG_SDENS]   = sdens;
        f[rpc_pkg::FLAG_SYM]     = sym;
        f[rpc_pkg::FLAG_TOTAL]   = refl && trich;
        f[rpc_pkg::FLAG_TRANS]   = trans;
        f[rpc_pkg::FLAG_TRICH]   = trich;
        return f;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_count_q = rpc_pkg::ELEM_COUNT_RESET;
            expected_flags.delete();
        end else begin
            // retire before queuing, so a result can never match a same-edge request
            if (i_out_valid && i_out_ready) begin
                if (expected_flags.size() == 0) begin
                    $error("property_flags: expected none, actual %05h", i_property_flags);
                    errors++;
                end else begin
                    want = expected_flags.pop_front();
                    if (want !== i_property_flags) begin
                        $error("property_flags: expected %05h, actual %05h",
                               want, i_property_flags);
                        errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_flags.push_back(relation_flags(i_relation_matrix, elem_count_q));
            if (i_cfg_wr_en)
                elem_count_q = i_cfg_wr_data;
        end
        o_pending    <= expected_flags.size();
        o_fail_count <= errors;
    end

endmodule

FILE: verif/tb.sv
module tb;

    localparam int MAX_ELEMENTS = 8;
    localparam int HOLD_CYCLES  = 64;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 90;

    localparam logic [63:0] DIRECTED [22] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h8040_2010_0804_0201, 64'h7FBF_DFEF_F7FB_FDFE,
        64'h0080_C0E0_F0F8_FCFE, 64'h80C0_E0F0_F8FC_FEFF,
        64'h7F3F_1F0F_0703_0100, 64'h0000_0000_0000_0002,
        64'h0000_0000_0000_0102, 64'h0000_0000_0000_0402,
        64'h0000_0000_0000_0406, 64'h0000_0000_0001_0402,
        64'h0000_0000_0000_0001, 64'h0000_0000_0000_0003,
        64'h0000_0000_0000_0202, 64'h0000_0000_0002_0006,
        64'hF0F0_F0F0_0F0F_0F0F, 64'h8000_0000_0000_0000,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        64'h80C0_E0F0_F8FC_FFFF, 64'h0000_0000_0006_0606
    };

    // set sizes per phase; the last phase picks one at random
    localparam logic [3:0] PHASE_SIZES [NUM_PHASES] = '{
        4'd0, 4'd1, 4'd15, 4'd2, 4'd9, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd8
    };

    typedef enum int {
        SHAPE_NOISE, SHAPE_SPARSE, SHAPE_DENSE, SHAPE_SYMMETRIC, SHAPE_CLOSURE,
        SHAPE_EQUIV, SHAPE_ORDER, SHAPE_DIAGONAL, SHAPE_SINGLE
    } t_shape;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [rpc_pkg::ELEM_COUNT_W-1:0] i_cfg_wr_data;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic [rpc_pkg::MATRIX_W-1:0]     i_relation_matrix;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [rpc_pkg::FLAGS_W-1:0]      o_property_flags;

    int pending;
    int fail_count;
    int hold_requests = 0;
    bit steady = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    relation_property_checker_unit #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_relation_matrix (i_relation_matrix),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_property_flags  (o_property_flags)
    );

    relation_flags_checker #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) flags_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_relation_matrix (i_relation_matrix),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_property_flags  (o_property_flags),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    function automatic logic [63:0] random_relation();
        logic [63:0] r;
        t_shape shape;
        int i, j, k, t, d;
        int label [8];
        int perm [8];
        bit strict;

        r = '0;
        shape = t_shape'($urandom_range(0, 8));
        case (shape)
            SHAPE_NOISE: begin
                r = {$urandom, $urandom};
            end
            SHAPE_SPARSE, SHAPE_SYMMETRIC, SHAPE_CLOSURE: begin
                for (i = 0; i < 64; i++)
                    if ($urandom_range(0, 9) == 0)
                        r[i] = 1'b1;
            end
            SHAPE_DENSE: begin
                for (i = 0; i < 64; i++)
                    if ($urandom_range(0, 7) != 0)
                        r[i] = 1'b1;
            end
            SHAPE_EQUIV: begin
                for (i = 0; i < 8; i++)
                    label[i] = $urandom_range(0, 3);
                for (i = 0; i < 8; i++)
                    for (j = 0; j < 8; j++)
                        r[8*i+j] = (label[i] == label[j]);
            end
            SHAPE_ORDER: begin
                for (i = 0; i < 8; i++)
                    perm[i] = i;
                for (i = 7; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    t = perm[i];
                    perm[i] = perm[j];
                    perm[j] = t;
                end
                strict = 1'($urandom_range(0, 1));
                for (i = 0; i < 8; i++)
                    for (j = 0; j < 8; j++)
                        if (i < j || (i == j && !strict))
                            r[8*perm[i]+perm[j]] = 1'b1;
            end
            SHAPE_DIAGONAL: begin
                for (i = 0; i < 8; i++)
                    r[9*i] = 1'($urandom_range(0, 1));
            end
            default: begin
                r[$urandom_range(0, 63)] = 1'b1;
            end
        endcase

        if (shape == SHAPE_SYMMETRIC)
            for (i = 0; i < 8; i++)
                for (j = 0; j < 8; j++)
                    if (r[8*i+j])
                        r[8*j+i] = 1'b1;
        if (shape == SHAPE_CLOSURE)
            for (k = 0; k < 8; k++)
                for (i = 0; i < 8; i++)
                    for (j = 0; j < 8; j++)
                        if (r[8*i+k] && r[8*k+j])
                            r[8*i+j] = 1'b1;

        if (shape != SHAPE_NOISE) begin
            d = $urandom_range(0, 3);
            for (i = 0; i < 8; i++) begin
                if (d == 0)
                    r[9*i] = 1'b1;
                else if (d == 1)
                    r[9*i] = 1'b0;
            end
            // occasionally break the structure by one bit
            if ($urandom_range(0, 5) == 0) begin
                t = $urandom_range(0, 63);
                r[t] = ~r[t];
            end
        end
        return r;
    endfunction

    task automatic send_relation(input logic [63:0] rel);
        int gap;
        if (!steady && $urandom_range(0, 99) < 6) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_relation_matrix <= rel;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_elem_count(input logic [3:0] value);
        wait_drained();
        // let the pipeline settle before touching the register
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // output side: random stalls plus one long hold-off on demand
    initial begin : receiver
        int served;
        served = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests > served) begin
                served++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= steady || ($urandom_range(0, 99) >= 6);
        end
    end

    initial begin
        #2_000_000;
        $display("relation_property_checker_unit test failed");
        $finish;
    end

    initial begin : stimulus
        int p, idx;
        logic [3:0] size;

        i_rst_n           <= 1'b0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_wr_data     <= '0;
        i_in_valid        <= 1'b0;
        i_relation_matrix <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[d])
            send_relation(DIRECTED[d]);

        for (p = 0; p < NUM_PHASES; p++) begin
            size = (p == NUM_PHASES - 1) ? 4'($urandom_range(0, 15)) : PHASE_SIZES[p];
            write_elem_count(size);
            steady <= (p == NUM_PHASES - 2);
            for (idx = 0; idx < 4; idx++)
                send_relation(DIRECTED[idx]);
            for (idx = 0; idx < PHASE_ITEMS; idx++) begin
                if (p == 5 && idx == PHASE_ITEMS / 4)
                    hold_requests <= hold_requests + 1;
                if (p == 3 && idx == PHASE_ITEMS / 2)
                    wait_drained();
                send_relation(random_relation());
            end
        end
        steady <= 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("relation_property_checker_unit test passed");
        else
            $display("relation_property_checker_unit test failed");
        $finish;
    end

endmodule
